// ===== hdl/tkr_pkg.sv =====
package tkr_pkg;

   localparam int MAX_KEPT_DEFAULT = 32;
   localparam int LIMIT_W          = 6;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);
   localparam int COORD_W          = 32;
   localparam int HIT_W            = 16;
   localparam int DIST_W           = 2 * COORD_W;

   typedef enum logic {
      CMD_OFFER = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef struct packed {
      logic        [HIT_W-1:0]   count;
      logic        [DIST_W-1:0]  sq_sum;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift_up;
   } cell_ctrl_type;

   // true when a ranks strictly above b
   function automatic logic tkr_better(entry_type a, entry_type b);
      logic result;
      if (a.count != b.count) begin
         result = a.count > b.count;
      end else if (a.sq_sum != b.sq_sum) begin
         result = a.sq_sum < b.sq_sum;
      end else if (a.x != b.x) begin
         result = a.x < b.x;
      end else begin
         result = a.z < b.z;
      end
      return result;
   endfunction

endpackage

// ===== hdl/tkr_dist.sv =====
module tkr_dist
   import tkr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  cmd_type                   in_cmd,
   input  logic signed [COORD_W-1:0] in_x,
   input  logic signed [COORD_W-1:0] in_z,
   input  logic        [HIT_W-1:0]   in_count,
   output logic                      out_valid,
   output cmd_type                   out_cmd,
   output entry_type                 out_entry,
   output logic                      drain_pending
);

   logic                      s1_valid_ff, s1_valid_in;
   cmd_type                   s1_cmd_ff;
   logic signed [COORD_W-1:0] s1_x_ff;
   logic signed [COORD_W-1:0] s1_z_ff;
   logic        [HIT_W-1:0]   s1_count_ff;
   logic        [DIST_W-1:0]  s1_sqx_ff, s1_sqz_ff;
   logic                      s2_valid_ff, s2_valid_in;
   cmd_type                   s2_cmd_ff;
   entry_type                 s2_entry_ff, s2_entry_in;
   logic        [COORD_W-1:0] mag_x, mag_z;

   always_comb begin
      mag_x = in_x[COORD_W-1] ? (~in_x + 1'b1) : in_x;
      mag_z = in_z[COORD_W-1] ? (~in_z + 1'b1) : in_z;
      s1_valid_in = in_valid;
      s2_valid_in = s1_valid_ff;
      s2_entry_in.count  = s1_count_ff;
      s2_entry_in.sq_sum = s1_sqx_ff + s1_sqz_ff;
      s2_entry_in.x      = s1_x_ff;
      s2_entry_in.z      = s1_z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= in_cmd;
      s1_x_ff     <= in_x;
      s1_z_ff     <= in_z;
      s1_count_ff <= in_count;
      s1_sqx_ff   <= DIST_W'(mag_x) * DIST_W'(mag_x);
      s1_sqz_ff   <= DIST_W'(mag_z) * DIST_W'(mag_z);
      s2_cmd_ff   <= s1_cmd_ff;
      s2_entry_ff <= s2_entry_in;
   end

   assign out_valid     = s2_valid_ff;
   assign out_cmd       = s2_cmd_ff;
   assign out_entry     = s2_entry_ff;
   assign drain_pending = (s1_valid_ff && s1_cmd_ff == CMD_DRAIN)
                       || (s2_valid_ff && s2_cmd_ff == CMD_DRAIN);

endmodule

// ===== hdl/tkr_cell.sv =====
module tkr_cell
   import tkr_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     prev_entry,
   input  entry_type     next_entry,
   input  logic          self_valid,
   input  logic          prev_ins,
   output entry_type     entry,
   output logic          ins
);

   entry_type entry_ff, entry_in;

   // new entry belongs at or above this slot
   assign ins = !self_valid || tkr_better(new_entry, entry_ff);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_up) begin
         entry_in = next_entry;
      end else if (ctrl.insert && ins) begin
         entry_in = prev_ins ? prev_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hdl/top_k_result_retainer.sv =====
// Channel  Dir  Handshake              Beat
// req      in   req_valid/req_ready    command, coord_x, coord_z, hit_count
// rsp      out  rsp_valid/rsp_ready    out_x, out_z, out_count, last_flag
// csr      in   csr_wr_en              keep limit
//
// Offers: one per cycle while req_ready is high; squares register in s1, their sum in s2,
// and the entry then lands in the sorted cell row.
// Drain: req_ready drops once the drain beat is taken and stays low until the row has
// emptied; once the drain beat has passed s1 and s2 and set drain_busy, the row shifts
// up one entry into rsp per cycle in which rsp can take a beat.
// Reset: clears fill count, handshake state and sets the keep limit to 20; cell
// contents are not cleared. Stalls on rsp hold the row.
module top_k_result_retainer
   import tkr_pkg::*;
#(
   parameter int MAX_KEPT = MAX_KEPT_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic signed [COORD_W-1:0]     req_coord_x,
   input  logic signed [COORD_W-1:0]     req_coord_z,
   input  logic        [HIT_W-1:0]       req_hit_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_W-1:0]     rsp_out_x,
   output logic signed [COORD_W-1:0]     rsp_out_z,
   output logic        [HIT_W-1:0]       rsp_out_count,
   output logic                          rsp_last_flag,
   input  logic                          csr_wr_en,
   input  logic        [LIMIT_W-1:0]     csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam int CAP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   logic [LIMIT_W-1:0]     keep_limit_ff, keep_limit_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic                   drain_busy_ff, drain_busy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_z_ff;
   logic        [HIT_W-1:0]   rsp_count_ff;
   logic                      rsp_last_ff;

   logic          pipe_valid;
   cmd_type       pipe_cmd;
   entry_type     pipe_entry;
   logic          drain_pending;
   logic          offer_go, drain_go, pop, full;
   logic [CAP_W-1:0] tc_wide, cap;
   cell_ctrl_type ctrl;

   entry_type cell_entry [MAX_KEPT];
   logic      cell_ins   [MAX_KEPT];

   assign req_ready = !drain_busy_ff && !drain_pending;

   tkr_dist u_dist (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid && req_ready),
      .in_cmd        (cmd_type'(req_command)),
      .in_x          (req_coord_x),
      .in_z          (req_coord_z),
      .in_count      (req_hit_count),
      .out_valid     (pipe_valid),
      .out_cmd       (pipe_cmd),
      .out_entry     (pipe_entry),
      .drain_pending (drain_pending)
   );

   genvar i;
   generate
      for (i = 0; i < MAX_KEPT; i++) begin : g_cell
         entry_type prev_e, next_e;
         logic      prev_i;
         if (i == 0) begin : g_first
            assign prev_e = pipe_entry;
            assign prev_i = 1'b0;
         end else begin : g_mid
            assign prev_e = cell_entry[i-1];
            assign prev_i = cell_ins[i-1];
         end
         if (i == MAX_KEPT - 1) begin : g_last
            assign next_e = cell_entry[i];
         end else begin : g_inner
            assign next_e = cell_entry[i+1];
         end
         tkr_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .new_entry  (pipe_entry),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .self_valid (used_ff > CNT_W'(i)),
            .prev_ins   (prev_i),
            .entry      (cell_entry[i]),
            .ins        (cell_ins[i])
         );
      end
   endgenerate

   always_comb begin
      tc_wide = CAP_W'(keep_limit_ff);
      if (tc_wide == '0) begin
         cap = CAP_W'(1);
      end else if (tc_wide > CAP_W'(MAX_KEPT)) begin
         cap = CAP_W'(MAX_KEPT);
      end else begin
         cap = tc_wide;
      end
      full     = CAP_W'(used_ff) >= cap;
      offer_go = pipe_valid && pipe_cmd == CMD_OFFER;
      drain_go = pipe_valid && pipe_cmd == CMD_DRAIN;
      pop      = drain_busy_ff && (!rsp_valid_ff || rsp_ready);
      ctrl.insert   = offer_go;
      ctrl.shift_up = pop;

      keep_limit_in = csr_wr_en ? csr_wr_data : keep_limit_ff;

      priority if (pop) begin
         used_in = used_ff - 1'b1;
      end else if (offer_go && !full) begin
         used_in = used_ff + 1'b1;
      end else begin
         used_in = used_ff;
      end

      priority if (drain_go) begin
         drain_busy_in = used_ff != '0;
      end else if (pop && used_ff == CNT_W'(1)) begin
         drain_busy_in = 1'b0;
      end else begin
         drain_busy_in = drain_busy_ff;
      end

      priority if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_limit_ff <= LIMIT_RESET;
         used_ff       <= '0;
         drain_busy_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         keep_limit_ff <= keep_limit_in;
         used_ff       <= used_in;
         drain_busy_ff <= drain_busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_x_ff     <= cell_entry[0].x;
         rsp_z_ff     <= cell_entry[0].z;
         rsp_count_ff <= cell_entry[0].count;
         rsp_last_ff  <= used_ff == CNT_W'(1);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_z     = rsp_z_ff;
   assign rsp_out_count = rsp_count_ff;
   assign rsp_last_flag = rsp_last_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAX_KEPT))
      else $error("fill count above row length");

   a_no_req_in_drain: assert property (@(posedge clock) disable iff (reset)
      drain_busy_ff |-> !req_ready)
      else $error("request taken while draining");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && used_ff == CNT_W'(1)) |=> (!drain_busy_ff && rsp_last_ff))
      else $error("drain still busy after last beat");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      (offer_go && !full && !pop) |=> used_ff == $past(used_ff) + 1'b1)
      else $error("offer into non-full row did not grow it");

   a_drain_empty_pipe: assert property (@(posedge clock) disable iff (reset)
      pop |-> !(pipe_valid && pipe_cmd == CMD_OFFER))
      else $error("offer arrived during drain");
`endif

endmodule
